// ===== hdl/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared widths, constants, phase codes, controller states and the
// command and status words between the controller and the datapath.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int unsigned TIME_W  = 24;
    localparam int unsigned LEVEL_W = 17;
    localparam int unsigned TIMER_W = 32;
    localparam int unsigned GATE_W  = 16;
    localparam int unsigned STEP_W  = 16;
    localparam int unsigned QUO_W   = 16;
    localparam int unsigned PROD_W  = TIMER_W + LEVEL_W;
    localparam int unsigned CNT_W   = $clog2(QUO_W);
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0]       FULL_SCALE = 17'h10000;
    localparam logic signed [GATE_W-1:0] GATE_ONE   = 16'sd4096;
    localparam logic signed [GATE_W-1:0] GATE_ZERO  = 16'sd0;
    localparam logic [TIMER_W-1:0]       TIMER_MAX  = '1;
    localparam logic [CNT_W-1:0]         CNT_LAST   = CNT_W'(QUO_W - 1);

    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK  = 2'd0,
        CFG_DECAY   = 2'd1,
        CFG_SUSTAIN = 2'd2,
        CFG_RELEASE = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RULE,
        S_ADV,
        S_EVAL,
        S_MUL,
        S_PREP,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic rule;
        logic advance;
        logic eval;
        logic mul;
        logic prep;
        logic div_step;
        logic finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_ovf;
        logic div_last;
    } t_stat;

endpackage

// ===== hdl/adsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope controller
// Sequences one word through gate rule, timer advance, level evaluation,
// multiply, serial divide and output load, and owns the output valid flag.
// ----------------------------------------------------------------------------
module adsr_ctrl import adsr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RULE;
                end
            end
            S_RULE: begin
                o_cmd.rule = 1'b1;
                n_state    = S_ADV;
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.need_div ? S_MUL : S_OUT;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_stat.div_ovf ? S_OUT : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/adsr_dp.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope datapath
// Holds the configuration, phase and timers, and computes the ramp level
// with one multiplier and a restoring divider that yields one bit a cycle.
// ----------------------------------------------------------------------------
module adsr_dp import adsr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [TIME_W-1:0]        i_cfg_data,
    input  logic signed [GATE_W-1:0] i_gate_level,
    input  logic [STEP_W-1:0]        i_time_step,
    output logic [LEVEL_W-1:0]       o_envelope_level,
    output logic [2:0]               o_phase
);

    logic [TIME_W-1:0]        r_attack_time;
    logic [TIME_W-1:0]        r_decay_time;
    logic [LEVEL_W-1:0]       r_sustain_level;
    logic [TIME_W-1:0]        r_release_time;
    t_phase                   r_phase;
    logic                     r_gate_held;
    logic [TIMER_W-1:0]       r_attack_elapsed;
    logic [TIMER_W-1:0]       r_release_elapsed;
    logic signed [GATE_W-1:0] r_gate;
    logic [STEP_W-1:0]        r_delta;
    logic [TIMER_W-1:0]       r_mul_a;
    logic [LEVEL_W-1:0]       r_mul_b;
    logic [TIME_W-1:0]        r_div_d;
    t_phase                   r_mode;
    logic [LEVEL_W-1:0]       r_level;
    logic [PROD_W-1:0]        r_prod;
    logic [TIME_W-1:0]        r_rem;
    logic [QUO_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_cnt;
    logic [LEVEL_W-1:0]       r_out_level;
    t_phase                   r_out_phase;

    logic [TIMER_W-1:0]  attack_ext;
    logic [TIMER_W-1:0]  release_ext;
    logic                gate_high;
    logic                gate_low;
    logic                attack_over;
    logic                decay_over;
    logic [TIMER_W:0]    attack_sum;
    logic [TIMER_W:0]    release_sum;
    logic [LEVEL_W-1:0]  n_level;
    logic                need_div;
    logic [TIMER_W-1:0]  n_mul_a;
    logic [LEVEL_W-1:0]  n_mul_b;
    logic [TIME_W-1:0]   n_div_d;
    logic [TIME_W:0]     div_shift;
    logic [TIME_W:0]     div_diff;
    logic                div_ge;
    logic [LEVEL_W-1:0]  cfg_sustain;

    assign attack_ext  = {{(TIMER_W-TIME_W){1'b0}}, r_attack_time};
    assign release_ext = {{(TIMER_W-TIME_W){1'b0}}, r_release_time};
    assign gate_high   = (r_gate >= GATE_ONE);
    assign gate_low    = (r_gate <= GATE_ZERO);
    assign attack_over = (r_attack_elapsed > attack_ext);
    assign decay_over  = ({1'b0, r_attack_elapsed} >
                          ({1'b0, attack_ext} + {{(TIMER_W-TIME_W+1){1'b0}}, r_decay_time}));
    assign attack_sum  = {1'b0, r_attack_elapsed} + {{(TIMER_W-STEP_W+1){1'b0}}, r_delta};
    assign release_sum = {1'b0, r_release_elapsed} + {{(TIMER_W-STEP_W+1){1'b0}}, r_delta};
    assign cfg_sustain = (i_cfg_data[LEVEL_W-1:0] > FULL_SCALE) ? FULL_SCALE
                                                                : i_cfg_data[LEVEL_W-1:0];

    always_comb begin
        n_level  = '0;
        need_div = 1'b0;
        n_mul_a  = '0;
        n_mul_b  = '0;
        n_div_d  = '0;
        unique case (r_phase)
            PH_ATTACK: begin
                if (r_attack_time == '0 || r_attack_elapsed >= attack_ext) begin
                    n_level = FULL_SCALE;
                end else begin
                    need_div = 1'b1;
                    n_mul_a  = r_attack_elapsed;
                    n_mul_b  = FULL_SCALE;
                    n_div_d  = r_attack_time;
                end
            end
            PH_DECAY: begin
                if (r_decay_time == '0) begin
                    n_level = r_sustain_level;
                end else if (r_attack_elapsed <= attack_ext) begin
                    n_level = FULL_SCALE;
                end else begin
                    need_div = 1'b1;
                    n_mul_a  = r_attack_elapsed - attack_ext;
                    n_mul_b  = FULL_SCALE - r_sustain_level;
                    n_div_d  = r_decay_time;
                end
            end
            PH_SUSTAIN: begin
                n_level = r_sustain_level;
            end
            PH_RELEASE: begin
                if (r_release_time == '0 || r_release_elapsed >= release_ext) begin
                    n_level = '0;
                end else begin
                    need_div = 1'b1;
                    n_mul_a  = release_ext - r_release_elapsed;
                    n_mul_b  = r_sustain_level;
                    n_div_d  = r_release_time;
                end
            end
            default: begin
                n_level = '0;
            end
        endcase
    end

    assign div_shift = {r_rem, r_quo[QUO_W-1]};
    assign div_diff  = div_shift - {1'b0, r_div_d};
    assign div_ge    = (div_shift >= {1'b0, r_div_d});

    assign o_stat.need_div = need_div;
    assign o_stat.div_ovf  = (r_prod[PROD_W-1:QUO_W] >=
                              {{(PROD_W-QUO_W-TIME_W){1'b0}}, r_div_d});
    assign o_stat.div_last = (r_cnt == CNT_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_time     <= '0;
            r_decay_time      <= '0;
            r_sustain_level   <= FULL_SCALE;
            r_release_time    <= '0;
            r_phase           <= PH_OFF;
            r_gate_held       <= 1'b0;
            r_attack_elapsed  <= '0;
            r_release_elapsed <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_ATTACK:  r_attack_time   <= i_cfg_data;
                    CFG_DECAY:   r_decay_time    <= i_cfg_data;
                    CFG_SUSTAIN: r_sustain_level <= cfg_sustain;
                    CFG_RELEASE: r_release_time  <= i_cfg_data;
                    default:     r_attack_time   <= r_attack_time;
                endcase
            end
            if (i_cmd.rule) begin
                if (!r_gate_held && gate_high) begin
                    r_gate_held      <= 1'b1;
                    r_attack_elapsed <= '0;
                    r_phase          <= PH_ATTACK;
                end else if (r_gate_held && gate_low) begin
                    r_gate_held       <= 1'b0;
                    r_release_elapsed <= '0;
                    r_phase           <= PH_RELEASE;
                end else if (r_phase == PH_ATTACK && attack_over) begin
                    r_phase <= PH_DECAY;
                end else if (r_phase == PH_DECAY && decay_over) begin
                    r_phase <= PH_SUSTAIN;
                end
            end
            if (i_cmd.advance) begin
                if (r_phase == PH_ATTACK || r_phase == PH_DECAY) begin
                    r_attack_elapsed <= attack_sum[TIMER_W] ? TIMER_MAX
                                                            : attack_sum[TIMER_W-1:0];
                end else if (r_phase == PH_RELEASE) begin
                    r_release_elapsed <= release_sum[TIMER_W] ? TIMER_MAX
                                                              : release_sum[TIMER_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gate  <= i_gate_level;
            r_delta <= i_time_step;
        end
        if (i_cmd.eval) begin
            r_level <= n_level;
            r_mul_a <= n_mul_a;
            r_mul_b <= n_mul_b;
            r_div_d <= n_div_d;
            r_mode  <= r_phase;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_mul_a) * PROD_W'(r_mul_b);
        end
        if (i_cmd.prep) begin
            r_rem   <= r_prod[QUO_W +: TIME_W];
            r_quo   <= r_prod[QUO_W-1:0];
            r_cnt   <= '0;
            r_level <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_diff[TIME_W-1:0] : div_shift[TIME_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], div_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.finish) begin
            r_level <= (r_mode == PH_DECAY) ? FULL_SCALE - {1'b0, r_quo} : {1'b0, r_quo};
        end
        if (i_cmd.out_load) begin
            r_out_level <= r_level;
            r_out_phase <= r_phase;
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_envelope_level = r_out_level;
    assign o_phase          = r_out_phase;

endmodule

// ===== hdl/adsr_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Gate-driven attack, decay, sustain and release envelope with one level
// word out for every gate and time step word in.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry the gate level (signed Q4.12)
// and the time step (unsigned Q0.16). Output channel: o_out_valid /
// i_out_stall carry the envelope level (Q1.16, 0..65536) and the phase.
// Configuration: i_cfg_valid / o_cfg_ready with a register index (0 attack
// time, 1 decay time, 2 sustain level, 3 release time) and write data; the
// port is always ready. The user must write it only while the block is
// idle; the block itself does not enforce this. A word whose level needs
// no ramp division skips the multiply and the divider; otherwise one
// multiply is followed by a restoring divider that yields one quotient
// bit per cycle for a 16-bit quotient, unless a decay ramp has already
// fallen to zero. One word is in work at a time, so o_in_stall is high
// from acceptance until its result is loaded into the output register.
// A finished word waits in the output register while the receiver stalls;
// the next word may be accepted meanwhile, and its result is held back until
// the register is free. Reset returns the phase to off, clears the gate
// hold, both timers and the output valid flag, and restores the defaults of
// all configuration registers.
// ----------------------------------------------------------------------------
module adsr_envelope_generator import adsr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [GATE_W-1:0] i_gate_level,
    input  logic [STEP_W-1:0]        i_time_step,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [LEVEL_W-1:0]       o_envelope_level,
    output logic [2:0]               o_phase,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [TIME_W-1:0]        i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    adsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    adsr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_gate_level     (i_gate_level),
        .i_time_step      (i_time_step),
        .o_envelope_level (o_envelope_level),
        .o_phase          (o_phase)
    );

endmodule

// ===== bench/tb_adsr_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope generator testbench
// Drives gate and time step words into the envelope generator and checks every
// envelope word that comes out against a table value or a running model.
// A short table of directed words covers zero times, hysteresis, a decay
// that starts before the attack end, saturated sustain and release past
// its end. Random envelopes follow, with register settings changed while the
// block is idle. Both handshakes idle at random outside one calm stretch.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_generator;
    import adsr_pkg::*;

    localparam int unsigned RANDOM_WORDS = 750;
    localparam int unsigned DRAIN_CYCLES = 30;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        t_phase             phase;
    } t_envelope_word;

    typedef struct packed {
        logic               is_cfg;
        t_cfg_idx           idx;
        logic [TIME_W-1:0]  data;
        logic [GATE_W-1:0]  gate;
        logic [STEP_W-1:0]  step;
        logic               known;
        logic [LEVEL_W-1:0] level;
        t_phase             phase;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [GATE_W-1:0] i_gate_level = '0;
    logic [STEP_W-1:0]        i_time_step = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [LEVEL_W-1:0]       o_envelope_level;
    logic [2:0]               o_phase;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [TIME_W-1:0]        i_cfg_data = '0;

    adsr_envelope_generator u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_gate_level     (i_gate_level),
        .i_time_step      (i_time_step),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_envelope_level (o_envelope_level),
        .o_phase          (o_phase),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    t_envelope_word expected_envelope[$];
    t_row           directed_rows[$];
    int unsigned    errors = 0;
    int unsigned    quiet_cycles = 0;
    logic           calm = 1'b0;

    logic [TIME_W-1:0]  set_attack = '0;
    logic [TIME_W-1:0]  set_decay = '0;
    logic [LEVEL_W-1:0] set_sustain = FULL_SCALE;
    logic [TIME_W-1:0]  set_release = '0;
    t_phase             env_phase = PH_OFF;
    logic               gate_high = 1'b0;
    logic [TIMER_W-1:0] attack_timer = '0;
    logic [TIMER_W-1:0] release_timer = '0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [TIMER_W-1:0] timer_add(logic [TIMER_W-1:0] a,
                                                     logic [STEP_W-1:0] b);
        logic [TIMER_W:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
    endfunction

    task automatic advance_envelope(input logic signed [GATE_W-1:0] gate,
                                    input logic [STEP_W-1:0] step,
                                    output t_envelope_word word);
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] full;
        logic [63:0] lvl;
        full = 64'(FULL_SCALE);
        if (!gate_high && gate >= GATE_ONE) begin
            gate_high = 1'b1;
            attack_timer = '0;
            env_phase = PH_ATTACK;
        end else if (gate_high && gate <= GATE_ZERO) begin
            gate_high = 1'b0;
            release_timer = '0;
            env_phase = PH_RELEASE;
        end else if (env_phase == PH_ATTACK && 64'(attack_timer) > 64'(set_attack)) begin
            env_phase = PH_DECAY;
        end else if (env_phase == PH_DECAY &&
                     64'(attack_timer) > 64'(set_attack) + 64'(set_decay)) begin
            env_phase = PH_SUSTAIN;
        end
        case (env_phase)
            PH_ATTACK: begin
                attack_timer = timer_add(attack_timer, step);
                if (set_attack == '0) begin
                    lvl = full;
                end else begin
                    q = {16'd0, attack_timer, 16'd0} / 64'(set_attack);
                    lvl = (q > full) ? full : q;
                end
            end
            PH_DECAY: begin
                attack_timer = timer_add(attack_timer, step);
                if (set_decay == '0) begin
                    lvl = 64'(set_sustain);
                end else if (64'(attack_timer) <= 64'(set_attack)) begin
                    lvl = full;
                end else begin
                    num = 64'(attack_timer) - 64'(set_attack);
                    q = num * (full - 64'(set_sustain)) / 64'(set_decay);
                    lvl = (q >= full) ? 64'd0 : full - q;
                end
            end
            PH_SUSTAIN: lvl = 64'(set_sustain);
            PH_RELEASE: begin
                release_timer = timer_add(release_timer, step);
                if (set_release == '0 || 64'(release_timer) >= 64'(set_release)) begin
                    lvl = 64'd0;
                end else begin
                    num = 64'(set_release) - 64'(release_timer);
                    q = num * 64'(set_sustain) / 64'(set_release);
                    lvl = (q > full) ? full : q;
                end
            end
            default: lvl = 64'd0;
        endcase
        word.level = lvl[LEVEL_W-1:0];
        word.phase = env_phase;
    endtask

    task automatic send_word(input logic signed [GATE_W-1:0] gate,
                             input logic [STEP_W-1:0] step,
                             output t_envelope_word word);
        i_in_valid <= 1'b1;
        i_gate_level <= gate;
        i_time_step <= step;
        do @(posedge i_clk); while (o_in_stall);
        advance_envelope(gate, step, word);
    endtask

    task automatic sender_gap();
        while (!calm && $urandom_range(0, 99) < 36) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [TIME_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ATTACK:  set_attack = data;
            CFG_DECAY:   set_decay = data;
            CFG_SUSTAIN: set_sustain = (data[LEVEL_W-1:0] > FULL_SCALE) ?
                                       FULL_SCALE : data[LEVEL_W-1:0];
            CFG_RELEASE: set_release = data;
            default: ;
        endcase
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_envelope.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_row cfg_row(t_cfg_idx idx, logic [TIME_W-1:0] data);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_row word_row(logic [GATE_W-1:0] gate, logic [STEP_W-1:0] step,
                                      logic known, logic [LEVEL_W-1:0] level,
                                      t_phase phase);
        t_row r;
        r = '0;
        r.gate = gate;
        r.step = step;
        r.known = known;
        r.level = level;
        r.phase = phase;
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] random_time();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return TIME_W'($urandom_range(1, 255));
            2: return TIME_W'($urandom_range(256, 1 << 20));
            3: return '1;
            default: return TIME_W'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] random_sustain();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return TIME_W'(FULL_SCALE);
            2: return TIME_W'($urandom);
            default: return TIME_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [GATE_W-1:0] random_gate(logic on);
        if ($urandom_range(0, 7) == 0) begin
            return GATE_W'($urandom);
        end else if ($urandom_range(0, 5) == 0) begin
            return GATE_W'($urandom_range(1, 4095));
        end else if (on) begin
            return GATE_W'($urandom_range(4096, 32767));
        end else begin
            return GATE_W'(0 - int'($urandom_range(0, 32768)));
        end
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 36);
    end

    always @(posedge i_clk) begin
        t_envelope_word exp_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_envelope.size() == 0) begin
                $display("%0t: unexpected word, level %0d phase %0d",
                         $time, o_envelope_level, o_phase);
                errors++;
            end else begin
                exp_word = expected_envelope.pop_front();
                if (o_envelope_level !== exp_word.level) begin
                    $display("%0t: level mismatch, expected %0d, actual %0d",
                             $time, exp_word.level, o_envelope_level);
                    errors++;
                end
                if (o_phase !== exp_word.phase) begin
                    $display("%0t: phase mismatch, expected %0d, actual %0d",
                             $time, exp_word.phase, o_phase);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_adsr_envelope_generator failed");
            $finish;
        end
    end

    initial begin
        t_envelope_word word;
        t_row           row;
        logic           prev_cfg;
        int unsigned    sent;
        int unsigned    env_count;
        int unsigned    n_on;
        int unsigned    n_off;
        int unsigned    step_max;

        directed_rows.push_back(word_row(16'sd0, 16'd0, 1'b1, 17'd0, PH_OFF));
        directed_rows.push_back(word_row(16'h8000, 16'hFFFF, 1'b1, 17'd0, PH_OFF));
        directed_rows.push_back(word_row(16'sd4095, 16'd1, 1'b1, 17'd0, PH_OFF));
        directed_rows.push_back(word_row(16'sd4096, 16'd0, 1'b1, FULL_SCALE, PH_ATTACK));
        directed_rows.push_back(word_row(16'sd32767, 16'hFFFF, 1'b1, FULL_SCALE, PH_ATTACK));
        directed_rows.push_back(word_row(16'sd1, 16'd1, 1'b1, FULL_SCALE, PH_DECAY));
        directed_rows.push_back(word_row(16'sd4096, 16'd7, 1'b1, FULL_SCALE, PH_SUSTAIN));
        directed_rows.push_back(word_row(16'sd0, 16'd0, 1'b1, 17'd0, PH_RELEASE));
        directed_rows.push_back(word_row(16'hFFFF, 16'd100, 1'b1, 17'd0, PH_RELEASE));
        directed_rows.push_back(cfg_row(CFG_ATTACK, 24'd4));
        directed_rows.push_back(cfg_row(CFG_DECAY, 24'd8));
        directed_rows.push_back(cfg_row(CFG_SUSTAIN, 24'd32768));
        directed_rows.push_back(cfg_row(CFG_RELEASE, 24'd16));
        directed_rows.push_back(word_row(16'sd4096, 16'd1, 1'b0, '0, PH_OFF));
        directed_rows.push_back(word_row(16'sd4096, 16'd4, 1'b0, '0, PH_OFF));
        directed_rows.push_back(word_row(16'sd4096, 16'd2, 1'b0, '0, PH_OFF));
        directed_rows.push_back(cfg_row(CFG_ATTACK, 24'd1000));
        directed_rows.push_back(word_row(16'sd4096, 16'd1, 1'b0, '0, PH_OFF));
        directed_rows.push_back(cfg_row(CFG_ATTACK, 24'd4));
        directed_rows.push_back(word_row(16'sd4096, 16'hFFFF, 1'b0, '0, PH_OFF));
        directed_rows.push_back(word_row(16'sd100, 16'd0, 1'b0, '0, PH_OFF));
        directed_rows.push_back(word_row(16'sd0, 16'd4, 1'b0, '0, PH_OFF));
        directed_rows.push_back(word_row(16'hFFFB, 16'hFFFF, 1'b0, '0, PH_OFF));
        directed_rows.push_back(cfg_row(CFG_SUSTAIN, 24'hFFFFFF));
        directed_rows.push_back(cfg_row(CFG_ATTACK, 24'hFFFFFF));
        directed_rows.push_back(cfg_row(CFG_RELEASE, 24'hFFFFFF));
        directed_rows.push_back(word_row(16'sd4096, 16'hFFFF, 1'b0, '0, PH_OFF));
        directed_rows.push_back(word_row(16'sd0, 16'hFFFF, 1'b0, '0, PH_OFF));
        directed_rows.push_back(cfg_row(CFG_SUSTAIN, 24'd0));
        directed_rows.push_back(cfg_row(CFG_DECAY, 24'hFFFFFF));
        directed_rows.push_back(word_row(16'sd32767, 16'd1, 1'b0, '0, PH_OFF));
        directed_rows.push_back(word_row(16'h8000, 16'd0, 1'b0, '0, PH_OFF));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        prev_cfg = 1'b0;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                if (!prev_cfg) settle();
                write_register(row.idx, row.data);
            end else begin
                i_cfg_valid <= 1'b0;
                sender_gap();
                send_word($signed(row.gate), row.step, word);
                expected_envelope.push_back(row.known ? {row.level, row.phase} : word);
            end
            prev_cfg = row.is_cfg;
        end
        if (prev_cfg) i_cfg_valid <= 1'b0;

        sent = 0;
        env_count = 0;
        while (sent < RANDOM_WORDS) begin
            if (env_count % 8 == 0) begin
                settle();
                write_register(CFG_ATTACK, random_time());
                write_register(CFG_DECAY, random_time());
                write_register(CFG_SUSTAIN, random_sustain());
                write_register(CFG_RELEASE, random_time());
                i_cfg_valid <= 1'b0;
            end
            n_on = $urandom_range(1, 24);
            n_off = $urandom_range(1, 12);
            case ($urandom_range(0, 2))
                0: step_max = 255;
                1: step_max = 4095;
                default: step_max = 65535;
            endcase
            for (int k = 0; k < n_on + n_off; k++) begin
                calm = (sent >= 300 && sent < 450);
                sender_gap();
                send_word($signed(random_gate(k < n_on)),
                          STEP_W'($urandom_range(0, step_max)), word);
                expected_envelope.push_back(word);
                sent++;
            end
            env_count++;
        end
        calm = 1'b0;

        settle();
        if (errors == 0 && expected_envelope.size() == 0) begin
            $display("tb_adsr_envelope_generator passed");
        end else begin
            $display("tb_adsr_envelope_generator failed");
        end
        $finish;
    end

endmodule
